// ===== rtl/kmls_pkg.sv =====
// ----------------------------------------------------------------------------
// kmls_pkg
// Shared types and constants for the key matrix lockout scanner.
// ----------------------------------------------------------------------------
package kmls_pkg;

  localparam int ROWS = 5;
  localparam int COLS = 5;
  localparam int MASK_BITS = 25;
  localparam int LEVEL_BITS = 5;

  localparam int ROW_FIELD_W = 3;
  localparam int COL_FIELD_W = 3;
  localparam int TIME_W = 32;
  localparam int LOCKOUT_W = 16;

  localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int MASK_IDX_W = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 25;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_MASK = 2'd1;

  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd50;
  localparam logic [MASK_BITS-1:0] MASK_RESET = {MASK_BITS{1'b1}};

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [ROW_FIELD_W-1:0] scan_row;
    logic [LEVEL_BITS-1:0]  column_levels;
    logic [TIME_W-1:0]      now_ms;
  } in_item_t;

  typedef struct packed {
    logic [COL_FIELD_W-1:0] key_column;
    logic [ROW_FIELD_W-1:0] key_row;
    logic                   last_event;
  } out_item_t;

  typedef struct packed {
    logic [ROW_FIELD_W-1:0] row;
    logic [COLS-1:0]        mask;
  } evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/kmls_front.sv =====
// ----------------------------------------------------------------------------
// kmls_front
// Holds the configuration and the per-key deadlines, updates one scanned row
// per accepted word and queues the mask of reported presses.
// ----------------------------------------------------------------------------
module kmls_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  kmls_pkg::in_item_t                   in_item,
  input  logic                                 cfg_write,
  input  logic [kmls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kmls_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  kmls_pkg::q_status_t                  q_status,
  output logic                                 push,
  output kmls_pkg::evt_t                       push_evt
);
  import kmls_pkg::*;

  logic [LOCKOUT_W-1:0] lockout_ms;
  logic [MASK_BITS-1:0] report_mask;
  logic [TIME_W-1:0]    deadline [ROWS][COLS];
  logic [TIME_W-1:0]    deadline_next [COLS];
  logic [COLS-1:0]      report;
  logic [ROW_IDX_W-1:0] row_sel;
  logic                 row_ok;
  logic                 accept;
  logic [TIME_W-1:0]    new_deadline;

  assign in_ready = !q_status.full;
  assign accept = in_valid && in_ready;
  assign row_sel = in_item.scan_row[ROW_IDX_W-1:0];
  assign row_ok = {{(32-ROW_FIELD_W){1'b0}}, in_item.scan_row} < 32'(ROWS);
  assign new_deadline = in_item.now_ms + {{(TIME_W-LOCKOUT_W){1'b0}}, lockout_ms};

  always_comb begin
    logic [TIME_W-1:0] cur;
    logic              pressed;
    logic              fire;
    int                key;
    for (int c = 0; c < COLS; c++) begin
      cur = deadline[row_sel][c];
      if (cur < in_item.now_ms) begin
        cur = '0;
      end
      pressed = (c < LEVEL_BITS) ? !in_item.column_levels[c] : 1'b0;
      fire = pressed && (cur == '0);
      deadline_next[c] = fire ? new_deadline : cur;
      key = int'(row_sel) * COLS + c;
      report[c] = fire && (key < MASK_BITS) && report_mask[key[MASK_IDX_W-1:0]];
    end
  end

  assign push = accept && row_ok && (|report);
  assign push_evt.row = in_item.scan_row;
  assign push_evt.mask = report;

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ms <= LOCKOUT_RESET;
      report_mask <= MASK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOCKOUT:     lockout_ms <= cfg_data[LOCKOUT_W-1:0];
        REG_REPORT_MASK: report_mask <= cfg_data[MASK_BITS-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          deadline[r][c] <= '0;
        end
      end
    end else if (accept && row_ok) begin
      for (int c = 0; c < COLS; c++) begin
        deadline[row_sel][c] <= deadline_next[c];
      end
    end
  end

endmodule

// ===== rtl/kmls_fifo.sv =====
// ----------------------------------------------------------------------------
// kmls_fifo
// Short queue of pending press masks between the row front and the event back.
// ----------------------------------------------------------------------------
module kmls_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  kmls_pkg::evt_t      push_evt,
  input  logic                pop,
  output kmls_pkg::evt_t      head,
  output kmls_pkg::q_status_t q_status
);
  import kmls_pkg::*;

  evt_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign head = entry[rd_ptr];
  assign q_status.full = (count == Q_CNT_W'(Q_DEPTH));
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/kmls_back.sv =====
// ----------------------------------------------------------------------------
// kmls_back
// Turns each queued press mask into one event word per key, lowest column
// first, and flags the final event of the row.
// ----------------------------------------------------------------------------
module kmls_back (
  input  logic                clk,
  input  logic                rst,
  input  kmls_pkg::evt_t      head,
  input  kmls_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output kmls_pkg::out_item_t out_item
);
  import kmls_pkg::*;

  logic                   work_valid;
  evt_t                   work;
  evt_t                   eff;
  logic                   eff_valid;
  logic                   slot_free;
  logic                   fire;
  logic [COLS-1:0]        low_bit;
  logic [COL_FIELD_W-1:0] sel_col;
  logic [COLS-1:0]        rem;

  assign eff_valid = work_valid || !q_status.empty;
  assign eff = work_valid ? work : head;
  assign slot_free = !out_valid || out_ready;
  assign fire = slot_free && eff_valid;
  assign pop = fire && !work_valid;

  always_comb begin
    low_bit = '0;
    sel_col = '0;
    for (int c = COLS - 1; c >= 0; c--) begin
      if (eff.mask[c]) begin
        low_bit = COLS'(1) << c;
        sel_col = COL_FIELD_W'(c);
      end
    end
  end

  assign rem = eff.mask & ~low_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      work_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid <= eff_valid;
      end
      if (fire) begin
        work_valid <= |rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.key_column <= sel_col;
      out_item.key_row <= eff.row;
      out_item.last_event <= !(|rem);
      work.row <= eff.row;
      work.mask <= rem;
    end
  end

endmodule

// ===== rtl/key_matrix_lockout_scanner.sv =====
// ----------------------------------------------------------------------------
// key_matrix_lockout_scanner
// Press detector with per-key lockout for a 5x5 key matrix.
// ----------------------------------------------------------------------------
// One scanned row word is accepted per clock while the queue is not full: the
// five key checks of a row (deadline expiry, press test, new deadline) run
// side by side in combinational logic, and the deadlines live in flip-flops
// cleared by reset. Reported presses wait in a four-entry queue, and the
// output side sends one event word per clock while the output is ready. The
// first event of a row passes through the queue and the output register after
// its row word is accepted. The input is held off only while the queue is
// full, which happens when rows carry more presses than the output drains.
module key_matrix_lockout_scanner (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  kmls_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output kmls_pkg::out_item_t             out_item,
  input  logic                            cfg_write,
  input  logic [kmls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmls_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kmls_pkg::*;

  logic      push;
  evt_t      push_evt;
  logic      pop;
  evt_t      head;
  q_status_t q_status;

  kmls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_evt  (push_evt)
  );

  kmls_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  kmls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/kmls_checker.sv =====
// ----------------------------------------------------------------------------
// kmls_checker
// Port-level checks for the key matrix lockout scanner, bound to the top.
// ----------------------------------------------------------------------------
module kmls_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input kmls_pkg::out_item_t out_item
);
  import kmls_pkg::*;

  // A stalled event word keeps its place and its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("event word changed or vanished while stalled");

  // Reset leaves an empty queue and no pending event.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // Events only name keys that exist in the matrix.
  a_key_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_item.key_column) < COLS) && (32'(out_item.key_row) < ROWS))
    else $error("event names a key outside the matrix");

  // Within one row the events climb in column order on the same row.
  a_col_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_item.last_event ##1 out_valid |->
      out_item.key_row == $past(out_item.key_row) &&
      out_item.key_column > $past(out_item.key_column))
    else $error("events of a row out of column order");

endmodule

bind key_matrix_lockout_scanner kmls_checker u_kmls_checker (.*);

// ===== test/tb_key_matrix_lockout_scanner.sv =====
// ----------------------------------------------------------------------------
// tb_key_matrix_lockout_scanner
// Self-checking testbench for the key matrix lockout scanner.
// ----------------------------------------------------------------------------
// Row scan words are driven through the valid/ready input while a scoreboard
// keeps its own copy of the per-key deadlines and registers and predicts the
// press events of every accepted word. Each event word taken from the output
// is compared field by field with the oldest prediction. A short directed
// sequence covers full rows, lockout expiry, ignored rows, deadline wrap, zero
// lockout and unreported keys; several register settings follow with random
// scans on a mostly advancing millisecond clock. Both sides idle at random,
// and once the output is held off long enough for the event queue to fill.
// ----------------------------------------------------------------------------
module tb_key_matrix_lockout_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import kmls_pkg::*;

  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 80;

  class press_scoreboard;
    logic [LOCKOUT_W-1:0] lockout;
    logic [MASK_BITS-1:0] report_mask;
    logic [TIME_W-1:0]    deadline [ROWS*COLS];
    out_item_t            events_due[$];
    int                   errors;

    function new();
      lockout = LOCKOUT_RESET;
      report_mask = MASK_RESET;
      foreach (deadline[k]) deadline[k] = '0;
      errors = 0;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LOCKOUT: begin
          lockout = data[LOCKOUT_W-1:0];
        end
        REG_REPORT_MASK: begin
          report_mask = data[MASK_BITS-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_word(in_item_t w);
      int key;
      int hits;
      out_item_t ev;
      if (w.scan_row >= ROWS) return;
      hits = 0;
      for (int c = 0; c < COLS; c++) begin
        key = w.scan_row * COLS + c;
        if (deadline[key] < w.now_ms) deadline[key] = '0;
        if (!w.column_levels[c] && deadline[key] == '0) begin
          deadline[key] = w.now_ms + lockout;
          if (report_mask[key]) begin
            ev.key_column = COL_FIELD_W'(c);
            ev.key_row = w.scan_row;
            ev.last_event = 1'b0;
            events_due.push_back(ev);
            hits++;
          end
        end
      end
      if (hits > 0) begin
        ev = events_due.pop_back();
        ev.last_event = 1'b1;
        events_due.push_back(ev);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (events_due.size() == 0) begin
        $error("unexpected event word: key_column %0d key_row %0d last_event %0d",
               got.key_column, got.key_row, got.last_event);
        errors++;
        return;
      end
      want = events_due.pop_front();
      if (got.key_column !== want.key_column) begin
        $error("key_column: expected %0d, actual %0d", want.key_column, got.key_column);
        errors++;
      end
      if (got.key_row !== want.key_row) begin
        $error("key_row: expected %0d, actual %0d", want.key_row, got.key_row);
        errors++;
      end
      if (got.last_event !== want.last_event) begin
        $error("last_event: expected %0d, actual %0d", want.last_event, got.last_event);
        errors++;
      end
    endfunction

    function int pending();
      return events_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  press_scoreboard keeper;
  logic [TIME_W-1:0] scan_clock = '0;
  int tx_burst = 0;
  bit hold_output = 1'b0;

  key_matrix_lockout_scanner i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5ns clk = ~clk;
  end

  function automatic int draw_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 30);
    return $urandom_range(0, 5);
  endfunction

  task automatic send_word(input in_item_t w);
    int gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    keeper.note_word(w);
  endtask

  task automatic send_scan(input int row, input logic [LEVEL_BITS-1:0] levels,
                           input logic [TIME_W-1:0] t);
    in_item_t w;
    w.scan_row = ROW_FIELD_W'(row);
    w.column_levels = levels;
    w.now_ms = t;
    send_word(w);
  endtask

  task automatic run_random(input int count);
    in_item_t w;
    int sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 19))
        0: scan_clock = $urandom;
        1: scan_clock = 32'hFFFF_FFFF - $urandom_range(0, 100);
        default: scan_clock = scan_clock + $urandom_range(0, 25);
      endcase
      if ($urandom_range(0, 9) == 0) w.scan_row = ROW_FIELD_W'($urandom_range(ROWS, 7));
      else w.scan_row = ROW_FIELD_W'($urandom_range(0, ROWS - 1));
      case ($urandom_range(0, 9))
        0, 1: w.column_levels = '1;
        2, 3: w.column_levels = '0;
        4, 5: w.column_levels = ~(LEVEL_BITS'(1) << $urandom_range(0, LEVEL_BITS - 1));
        default: w.column_levels = LEVEL_BITS'($urandom);
      endcase
      w.now_ms = scan_clock;
      send_word(w);
      sent++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    keeper.configure(idx, data);
  endtask

  task automatic write_lockout(input logic [LOCKOUT_W-1:0] value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data[LOCKOUT_W-1:0] = value;
    write_reg(REG_LOCKOUT, data);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (keeper.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    keeper = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_scan(0, 5'b00000, 32'd100);
    send_scan(0, 5'b00000, 32'd150);
    send_scan(0, 5'b00000, 32'd151);
    send_scan(4, 5'b01111, 32'd1000);
    send_scan(5, 5'b00000, 32'd1000);
    send_scan(6, 5'b00000, 32'd1000);
    send_scan(7, 5'b00000, 32'd1000);
    send_scan(2, 5'b11111, 32'd0);
    send_scan(3, 5'b10101, 32'hFFFF_FFFF);
    send_scan(1, 5'b00000, 32'hFFFF_FFCE);
    send_scan(1, 5'b00000, 32'hFFFF_FFCE);
    send_scan(2, 5'b11110, 32'd0);
    scan_clock = 32'd200;
    run_random(40);
    settle();

    write_lockout('0);
    write_reg(REG_REPORT_MASK, 25'h155_5555);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    send_scan(2, 5'b00000, 32'd500);
    send_scan(2, 5'b00000, 32'd500);
    send_scan(2, 5'b00000, 32'd501);
    scan_clock = 32'd501;
    run_random(40);
    settle();

    write_lockout(16'hFFFF);
    write_reg(REG_REPORT_MASK, '0);
    run_random(20);
    settle();

    write_lockout(LOCKOUT_W'($urandom_range(1, 40)));
    write_reg(REG_REPORT_MASK, CFG_DATA_W'($urandom));
    hold_output = 1'b1;
    run_random(70);
    settle();

    write_lockout(LOCKOUT_W'($urandom_range(0, 65535)));
    write_reg(REG_REPORT_MASK, MASK_RESET);
    run_random(40);
    settle();

    write_lockout(16'd7);
    run_random(40);
    settle();

    repeat (8) @(posedge clk);
    if (keeper.errors == 0 && keeper.pending() == 0) begin
      $display("key_matrix_lockout_scanner test passed");
    end else begin
      $display("key_matrix_lockout_scanner test failed");
    end
    $finish;
  end

  initial begin : receiver
    int gap;
    int rx_burst;
    rx_burst = 0;
    wait (rst === 1'b0);
    forever begin
      gap = draw_gap(rx_burst);
      if (hold_output) begin
        gap += LONG_HOLD;
        hold_output = 1'b0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      keeper.check_result(out_item);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("key_matrix_lockout_scanner test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kmls_pkg.sv
rtl/kmls_front.sv
rtl/kmls_fifo.sv
rtl/kmls_back.sv
rtl/key_matrix_lockout_scanner.sv
rtl/kmls_checker.sv
test/tb_key_matrix_lockout_scanner.sv
